@@ rtl/hsv_pkg.sv @@
// shared types, constants and helpers for the hsv to rgb converter
// no dependencies; compile first
package hsv_pkg;

   typedef logic [7:0] level_type;
   typedef logic [2:0] sector_type;

   localparam int unsigned HUE_BITS_DEF = 16;
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned BACK_STAGES  = 4;
   // front register + queue + back stages
   localparam int unsigned PIPE_CAPACITY = 1 + QUEUE_DEPTH + BACK_STAGES;

   localparam level_type LEVEL_MAX = 8'hFF;

   localparam sector_type SECTOR_RED_RISE_GREEN = 3'd0;
   localparam sector_type SECTOR_FALL_RED       = 3'd1;
   localparam sector_type SECTOR_RISE_BLUE      = 3'd2;
   localparam sector_type SECTOR_FALL_GREEN     = 3'd3;
   localparam sector_type SECTOR_RISE_RED       = 3'd4;

   // floor(y / 255) for y below 65280
   function automatic level_type div_by_255(input logic [15:0] y);
      logic [16:0] sum;
      sum = {1'b0, y} + 17'd1 + {9'd0, y[15:8]};
      return sum[15:8];
   endfunction

endpackage

@@ rtl/hsv_if.sv @@
// valid/ready channel interfaces for hsv pixels in and rgb pixels out
// depends on hsv_pkg
interface hsv_req_if #(
   parameter int unsigned HUE_BITS = hsv_pkg::HUE_BITS_DEF
);
   import hsv_pkg::*;

   logic                valid;
   logic                ready;
   logic [HUE_BITS-1:0] hue;
   level_type           saturation;
   level_type           brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_rsp_if;
   import hsv_pkg::*;

   logic      valid;
   logic      ready;
   level_type red;
   level_type green;
   level_type blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/hsv_front.sv @@
// front end: accepts a pixel, splits hue into sector and fraction, flags gray
// depends on hsv_pkg and hsv_req_if
module hsv_front #(
   parameter int unsigned HUE_BITS = hsv_pkg::HUE_BITS_DEF,
   parameter int unsigned DATA_W   = HUE_BITS + 20
) (
   input  logic              clock,
   input  logic              reset,
   hsv_req_if.sink           req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [DATA_W-1:0] push_data
);
   import hsv_pkg::*;

   logic                valid_ff, valid_in;
   logic                gray_ff, gray_in;
   sector_type          sector_ff, sector_in;
   logic [HUE_BITS-1:0] frac_ff, frac_in;
   level_type           sat_ff, bri_ff;
   logic [HUE_BITS+2:0] hue_x6;
   logic                take;

   assign req_chan.ready = !valid_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      hue_x6    = ({3'b000, req_chan.hue} << 2) + ({3'b000, req_chan.hue} << 1);
      sector_in = hue_x6[HUE_BITS+2:HUE_BITS];
      frac_in   = hue_x6[HUE_BITS-1:0];
      gray_in   = (req_chan.saturation == '0);
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         gray_ff   <= gray_in;
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
         sat_ff    <= req_chan.saturation;
         bri_ff    <= req_chan.brightness;
      end
   end

   assign push_valid = valid_ff;
   assign push_data  = {gray_ff, sector_ff, frac_ff, sat_ff, bri_ff};

endmodule

@@ rtl/hsv_queue.sv @@
// short fifo between the front end and the arithmetic back end
// depends on hsv_pkg
module hsv_queue #(
   parameter int unsigned DATA_W = 36,
   parameter int unsigned DEPTH  = hsv_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   import hsv_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/hsv_back.sv @@
// back end: four-stage pipeline forming p, q, t and routing them by sector
// depends on hsv_pkg and hsv_rsp_if
module hsv_back #(
   parameter int unsigned HUE_BITS = hsv_pkg::HUE_BITS_DEF,
   parameter int unsigned DATA_W   = HUE_BITS + 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [DATA_W-1:0] pop_data,
   hsv_rsp_if.source         rsp_chan
);
   import hsv_pkg::*;

   localparam int unsigned PW = HUE_BITS + 8;
   localparam logic [PW-1:0] FULL_SCALE = {LEVEL_MAX, {HUE_BITS{1'b0}}};
   localparam logic [HUE_BITS:0] ONE_TURN = {1'b1, {HUE_BITS{1'b0}}};

   logic advance;

   // unpacked queue item
   logic                u_gray;
   sector_type          u_sector;
   logic [HUE_BITS-1:0] u_frac;
   level_type           u_sat, u_bri;

   // stage 1: saturation products
   logic          s1_valid_ff;
   logic          s1_gray_ff;
   sector_type    s1_sector_ff;
   level_type     s1_bri_ff;
   logic [PW-1:0] s1_sf_ff, s1_sf_in;
   logic [PW-1:0] s1_sg_ff, s1_sg_in;
   logic [15:0]   s1_pm_ff, s1_pm_in;
   logic [PW:0]   sg_wide;
   logic [HUE_BITS:0] frac_rest;

   // stage 2: one minus s*f and one minus s*(1-f)
   logic          s2_valid_ff;
   logic          s2_gray_ff;
   sector_type    s2_sector_ff;
   level_type     s2_bri_ff;
   logic [PW-1:0] s2_dq_ff, s2_dq_in;
   logic [PW-1:0] s2_dt_ff, s2_dt_in;
   logic [15:0]   s2_pm_ff;

   // stage 3: scale by brightness
   logic          s3_valid_ff;
   logic          s3_gray_ff;
   sector_type    s3_sector_ff;
   level_type     s3_bri_ff;
   logic [PW+7:0] s3_mq_ff, s3_mq_in;
   logic [PW+7:0] s3_mt_ff, s3_mt_in;
   logic [15:0]   s3_pm_ff;

   // stage 4: divide by 255, route to channels
   logic      s4_valid_ff;
   level_type red_ff, red_in;
   level_type green_ff, green_in;
   level_type blue_ff, blue_in;
   level_type p_lvl, q_lvl, t_lvl;

   assign advance   = !s4_valid_ff || rsp_chan.ready;
   assign pop_ready = advance;

   assign {u_gray, u_sector, u_frac, u_sat, u_bri} = pop_data;

   always_comb begin
      frac_rest = ONE_TURN - {1'b0, u_frac};
      s1_sf_in  = u_sat * u_frac;
      sg_wide   = u_sat * frac_rest;
      s1_sg_in  = sg_wide[PW-1:0];
      s1_pm_in  = u_bri * (LEVEL_MAX - u_sat);

      s2_dq_in = FULL_SCALE - s1_sf_ff;
      s2_dt_in = FULL_SCALE - s1_sg_ff;

      s3_mq_in = s2_bri_ff * s2_dq_ff;
      s3_mt_in = s2_bri_ff * s2_dt_ff;

      p_lvl = div_by_255(s3_pm_ff);
      q_lvl = div_by_255(s3_mq_ff[PW+7:HUE_BITS]);
      t_lvl = div_by_255(s3_mt_ff[PW+7:HUE_BITS]);

      if (s3_gray_ff) begin
         red_in   = s3_bri_ff;
         green_in = s3_bri_ff;
         blue_in  = s3_bri_ff;
      end else begin
         case (s3_sector_ff)
            SECTOR_RED_RISE_GREEN: begin
               red_in = s3_bri_ff; green_in = t_lvl;     blue_in = p_lvl;
            end
            SECTOR_FALL_RED: begin
               red_in = q_lvl;     green_in = s3_bri_ff; blue_in = p_lvl;
            end
            SECTOR_RISE_BLUE: begin
               red_in = p_lvl;     green_in = s3_bri_ff; blue_in = t_lvl;
            end
            SECTOR_FALL_GREEN: begin
               red_in = p_lvl;     green_in = q_lvl;     blue_in = s3_bri_ff;
            end
            SECTOR_RISE_RED: begin
               red_in = t_lvl;     green_in = p_lvl;     blue_in = s3_bri_ff;
            end
            default: begin
               red_in = s3_bri_ff; green_in = p_lvl;     blue_in = q_lvl;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s1_gray_ff   <= u_gray;
         s1_sector_ff <= u_sector;
         s1_bri_ff    <= u_bri;
         s1_sf_ff     <= s1_sf_in;
         s1_sg_ff     <= s1_sg_in;
         s1_pm_ff     <= s1_pm_in;

         s2_gray_ff   <= s1_gray_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_bri_ff    <= s1_bri_ff;
         s2_dq_ff     <= s2_dq_in;
         s2_dt_ff     <= s2_dt_in;
         s2_pm_ff     <= s1_pm_ff;

         s3_gray_ff   <= s2_gray_ff;
         s3_sector_ff <= s2_sector_ff;
         s3_bri_ff    <= s2_bri_ff;
         s3_mq_ff     <= s3_mq_in;
         s3_mt_ff     <= s3_mt_in;
         s3_pm_ff     <= s2_pm_ff;

         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid = s4_valid_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

endmodule

@@ rtl/hsv_to_rgb_converter_top.sv @@
// top level of the hsv to rgb pixel converter
// depends on hsv_pkg, hsv_if, hsv_front, hsv_queue, hsv_back
//
//   channel   direction  payload                          handshake
//   req_chan  in         hue, saturation, brightness      valid / ready
//   rsp_chan  out        red, green, blue                 valid / ready
//
// one pixel per clock sustained while the output is not stalled; a transfer on
// req_chan passes through the front register, a queue slot, three arithmetic
// stages and the output register before it shows up on rsp_chan
// synchronous reset clears the valid flags, queue pointers and queue count only
// an output stall freezes the back pipeline; the two-entry queue and front
// register keep taking transfers until they fill, then req_chan.ready drops
module hsv_to_rgb_converter_top #(
   parameter int unsigned HUE_BITS = hsv_pkg::HUE_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   hsv_req_if.sink  req_chan,
   hsv_rsp_if.source rsp_chan
);
   import hsv_pkg::*;

   // queue item: gray flag, sector, hue fraction, saturation, brightness
   localparam int unsigned DATA_W = 1 + $bits(sector_type) + HUE_BITS + 2 * $bits(level_type);

   // front to queue
   logic              push_valid;
   logic              push_ready;
   logic [DATA_W-1:0] push_data;

   // queue to back
   logic              pop_valid;
   logic              pop_ready;
   logic [DATA_W-1:0] pop_data;

   // classify: sector, fraction, zero-saturation flag
   hsv_front #(
      .HUE_BITS (HUE_BITS),
      .DATA_W   (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples the front end from output stalls
   hsv_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // arithmetic: p, q, t and channel routing
   hsv_back #(
      .HUE_BITS (HUE_BITS),
      .DATA_W   (DATA_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ rtl/hsv_checker.sv @@
// port-level checks for the hsv to rgb converter, bound to the top level
// depends on hsv_pkg and hsv_to_rgb_converter_top
module hsv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input hsv_pkg::level_type rsp_red,
   input hsv_pkg::level_type rsp_green,
   input hsv_pkg::level_type rsp_blue
);
   import hsv_pkg::*;

   localparam int unsigned CNT_W = $clog2(PIPE_CAPACITY + 1);

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result without a pixel in flight
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result shown with no pixel in flight");

   // in-flight count never exceeds what the pipeline can hold
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(PIPE_CAPACITY))
      else $error("more pixels in flight than pipeline storage");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue)))
      else $error("stalled result changed or dropped");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red),
   .rsp_green (rsp_chan.green),
   .rsp_blue  (rsp_chan.blue)
);

@@ verif/hsv_to_rgb_converter_top_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for hsv_to_rgb_converter_top: a table of directed pixels, then random
// pixels, idle bursts on both sides; every result checked against typed rgb or an hsv model
// depends on hsv_pkg, hsv_if and the converter rtl
module hsv_to_rgb_converter_top_test;
   import hsv_pkg::*;

   localparam int unsigned HUE_W         = HUE_BITS_DEF;
   localparam int unsigned RANDOM_PIXELS = 2000;
   // last stretch of the random part runs with both sides always ready
   localparam int unsigned CALM_TAIL     = 300;
   // after the last owed result, wait on for any stray results
   localparam int unsigned DRAIN_CYCLES  = 20;

   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } rgb_pixel_type;

   // one hsv pixel to send; typed rows carry the rgb value read off by hand
   typedef struct {
      logic [HUE_W-1:0] hue;
      level_type        sat;
      level_type        val;
      bit               typed;
      rgb_pixel_type    want;
   } hsv_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsv_req_if #(.HUE_BITS(HUE_W)) req_bus ();
   hsv_rsp_if rsp_bus ();

   hsv_to_rgb_converter_top #(.HUE_BITS(HUE_W)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // rgb values still owed by the converter, oldest first
   rgb_pixel_type pending_rgb [$];
   int unsigned   mismatch_count = 0;
   // chance in percent that an idle burst starts on either side
   int unsigned   idle_pct = 0;
   int unsigned   stall_left = 0;

   // directed table: gray, black, pure hues, the wrap just below one full turn,
   // the weakest saturation, then every sector and the edges between sectors
   hsv_pixel_type directed_pixels [$] = '{
      '{16'h0000, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{16'hFFFF, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{16'h5555, 8'd0,   8'hAA,  1'b1, '{8'hAA,  8'hAA,  8'hAA}},
      '{16'h0000, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{16'hFFFF, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{16'h1234, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{16'h0000, 8'd255, 8'd128, 1'b1, '{8'd128, 8'd0,   8'd0}},
      '{16'h0000, 8'd1,   8'd255, 1'b1, '{8'd255, 8'd254, 8'd254}},
      '{16'h8000, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{16'd5461,  8'd200, 8'd180, 1'b0, '0},
      '{16'd16384, 8'd128, 8'd255, 1'b0, '0},
      '{16'd27307, 8'd77,  8'd99,  1'b0, '0},
      '{16'd38229, 8'd255, 8'd1,   1'b0, '0},
      '{16'd49152, 8'd1,   8'd254, 1'b0, '0},
      '{16'd60075, 8'd150, 8'd150, 1'b0, '0},
      '{16'd10922, 8'd255, 8'd255, 1'b0, '0},
      '{16'd10923, 8'd255, 8'd255, 1'b0, '0},
      '{16'd21845, 8'd200, 8'd255, 1'b0, '0},
      '{16'd21846, 8'd200, 8'd255, 1'b0, '0},
      '{16'd43690, 8'd255, 8'd200, 1'b0, '0},
      '{16'd43691, 8'd255, 8'd200, 1'b0, '0},
      '{16'd54613, 8'd99,  8'd250, 1'b0, '0},
      '{16'd54614, 8'd99,  8'd250, 1'b0, '0}
   };

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // exact rational hsv to rgb, each channel truncated toward zero
   function automatic rgb_pixel_type predict_rgb(input logic [HUE_W-1:0] hue,
                                                 input level_type sat, input level_type val);
      bit [63:0]     unit_turn;
      bit [63:0]     h6;
      bit [63:0]     frac;
      bit [63:0]     den;
      bit [63:0]     s;
      bit [63:0]     v;
      bit [63:0]     p;
      bit [63:0]     q;
      bit [63:0]     t;
      sector_type    sector;
      rgb_pixel_type px;
      unit_turn = 64'd1 << HUE_W;
      s = 64'(sat);
      v = 64'(val);
      if (s == 0) begin
         // no saturation: gray at the value level
         px = '{val, val, val};
      end else begin
         h6     = 64'(hue) * 6;
         sector = sector_type'(h6 >> HUE_W);
         frac   = h6 & (unit_turn - 1);
         den    = 255 * unit_turn;
         p      = v * (255 - s) / 255;
         q      = v * (den - s * frac) / den;
         t      = v * (den - s * (unit_turn - frac)) / den;
         case (sector)
            SECTOR_RED_RISE_GREEN: px = '{val, t[7:0], p[7:0]};
            SECTOR_FALL_RED:       px = '{q[7:0], val, p[7:0]};
            SECTOR_RISE_BLUE:      px = '{p[7:0], val, t[7:0]};
            SECTOR_FALL_GREEN:     px = '{p[7:0], q[7:0], val};
            SECTOR_RISE_RED:       px = '{t[7:0], p[7:0], val};
            default:               px = '{val, p[7:0], q[7:0]};
         endcase
      end
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns ERROR %s", $time, msg);
      mismatch_count++;
   endtask

   // one pixel transfer on the request side, with an optional idle burst ahead of it;
   // valid stays high between back-to-back pixels
   task automatic send_pixel(input hsv_pixel_type px);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= px.hue;
      req_bus.saturation <= px.sat;
      req_bus.brightness <= px.val;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      pending_rgb.push_back(px.typed ? px.want : predict_rgb(px.hue, px.sat, px.val));
   endtask

   // result side: check each transfer against the oldest owed pixel, then pick
   // the ready level for the next cycle (stalls come in random bursts)
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rgb.size() == 0) begin
            report_mismatch($sformatf("rgb %0d %0d %0d with no pixel outstanding",
                                      rsp_bus.red, rsp_bus.green, rsp_bus.blue));
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_bus.red !== want.red)
               report_mismatch($sformatf("red %0d, expected %0d", rsp_bus.red, want.red));
            if (rsp_bus.green !== want.green)
               report_mismatch($sformatf("green %0d, expected %0d", rsp_bus.green, want.green));
            if (rsp_bus.blue !== want.blue)
               report_mismatch($sformatf("blue %0d, expected %0d", rsp_bus.blue, want.blue));
         end
      end
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // stimulus and end of run
   initial begin
      hsv_pixel_type px;
      int unsigned   sector_k;
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= '0;
      req_bus.saturation <= '0;
      req_bus.brightness <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct <= 25;
      @(posedge clock);

      foreach (directed_pixels[i])
         send_pixel(directed_pixels[i]);

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         // idle pressure changes every 200 pixels, none at all in the calm tail
         if (n == RANDOM_PIXELS - CALM_TAIL)
            idle_pct <= 0;
         else if (n < RANDOM_PIXELS - CALM_TAIL && n % 200 == 0)
            idle_pct <= $urandom_range(0, 3) * 15;
         px.typed = 1'b0;
         px.want  = '0;
         px.hue   = HUE_W'($urandom);
         px.sat   = level_type'($urandom);
         px.val   = level_type'($urandom);
         // bias part of the stream toward gray, full levels and sector edges
         case ($urandom_range(9))
            0: px.sat = '0;
            1: px.sat = LEVEL_MAX;
            2: px.val = LEVEL_MAX;
            3: begin
               sector_k = $urandom_range(1, 5);
               px.hue = HUE_W'((sector_k * (64'd1 << HUE_W) + 5) / 6 - $urandom_range(0, 2));
            end
            default: ;
         endcase
         send_pixel(px);
      end
      req_bus.valid <= 1'b0;

      while (pending_rgb.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ hsv_to_rgb_converter_top.f @@
rtl/hsv_pkg.sv
rtl/hsv_if.sv
rtl/hsv_front.sv
rtl/hsv_queue.sv
rtl/hsv_back.sv
rtl/hsv_to_rgb_converter_top.sv
rtl/hsv_checker.sv
verif/hsv_to_rgb_converter_top_test.sv
